>>> sv/lru_pkg.sv
// Package with shared constants and control/status types for the LRU page tracker.
package lru_pkg;

  // Default build sizes.
  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  // Fixed field widths of the stream words.
  localparam int PAGE_W  = 16;
  localparam int FAULT_W = 16;
  localparam int OCC_W   = 5;
  localparam int NF_W    = 5;

  // Reset value of the frame-count register.
  localparam logic [NF_W-1:0] NUM_FRAMES_RST = 5'd4;

  // Saturation value of the fault counter.
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word
    logic compare;  // register the match vector
    logic update;   // apply the recency update and write the result word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;  // result register holds a word not yet taken
  } dp_stat_t;

endpackage

>>> sv/lru_ctrl.sv
// Controller state machine that sequences capture, compare and update of each request.
module lru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               out_tready,
  input  lru_pkg::dp_stat_t  stat,
  output lru_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       upd_go;

  // The update may only run when the result register is free or being drained.
  assign upd_go = (state_r == S_UPD) && (!stat.out_full || out_tready);

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.load    = in_tvalid && (state_r == S_IDLE);
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.update  = upd_go;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/lru_dpath.sv
// Datapath holding the recency list, fault counter, frame-count register and result word.
module lru_dpath #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lru_pkg::ctrl_cmd_t           cmd,
  output lru_pkg::dp_stat_t            stat,
  input  logic [lru_pkg::PAGE_W-1:0]   in_page,
  input  logic                         in_eos,
  input  logic                         cfg_we,
  input  logic [lru_pkg::NF_W-1:0]     cfg_wdata,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic                         out_ev_valid,
  output logic [lru_pkg::PAGE_W-1:0]   out_ev_page,
  output logic [lru_pkg::FAULT_W-1:0]  out_fault,
  output logic [lru_pkg::OCC_W-1:0]    out_occ
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (CW > lru_pkg::NF_W) ? CW : lru_pkg::NF_W;

  // Recency list, slot 0 least recently used.
  logic [PAGE_BITS-1:0] list_r [MAX_FRAMES];
  // Value each slot takes when the list shifts down by one.
  logic [PAGE_BITS-1:0] list_up [MAX_FRAMES];

  logic [PAGE_BITS-1:0]          page_r;
  logic                          eos_r;
  logic [MAX_FRAMES-1:0]         match_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [lru_pkg::FAULT_W-1:0]   fault_r;
  logic [lru_pkg::FAULT_W-1:0]   fault_nxt;
  logic [lru_pkg::NF_W-1:0]      nf_r;

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic                          out_ev_valid_r;
  logic [lru_pkg::PAGE_W-1:0]    out_ev_page_r;
  logic [lru_pkg::FAULT_W-1:0]   out_fault_r;
  logic [lru_pkg::OCC_W-1:0]     out_occ_r;

  logic [LW-1:0]         nf_ext;
  logic [LW-1:0]         limit;
  logic                  hit;
  logic                  full;
  logic                  do_shift;
  logic [CW-1:0]         tail;
  logic [MAX_FRAMES-1:0] shift_mask;

  // Effective frame limit, clamped to 1..MAX_FRAMES.
  always_comb begin
    nf_ext = LW'(nf_r);
    if (nf_ext == '0) begin
      limit = LW'(1);
    end else if (nf_ext > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = nf_ext;
    end
  end

  // Resident pages are distinct, so the match vector is one-hot or empty.
  assign hit      = |match_r;
  assign full     = (LW'(count_r) >= limit);
  assign do_shift = hit || full;
  assign tail     = do_shift ? (count_r - CW'(1)) : count_r;
  // Slots at and above the hit position move down; an eviction shifts from slot 0.
  assign shift_mask = hit ? ~(match_r - MAX_FRAMES'(1)) : '1;

  // Next occupancy and fault count as reported with this request.
  always_comb begin
    count_nxt = count_r;
    fault_nxt = fault_r;
    if (!hit) begin
      if (fault_r != lru_pkg::FAULT_MAX) begin
        fault_nxt = fault_r + lru_pkg::FAULT_W'(1);
      end
      if (!full) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  // Capture the request word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= PAGE_BITS'(in_page);
      eos_r  <= in_eos;
    end
  end

  // Shift source for each slot; the top slot never shifts.
  always_comb begin
    for (int k = 0; k < MAX_FRAMES - 1; k++) begin
      list_up[k] = list_r[k+1];
    end
    list_up[MAX_FRAMES-1] = page_r;
  end

  // Compare the request against every resident slot.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        match_r[k] <= (list_r[k] == page_r) && (CW'(k) < count_r);
      end
    end
  end

  // List update: shift the affected slots down and place the page at the tail.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (CW'(k) == tail) begin
          list_r[k] <= page_r;
        end else if (do_shift && shift_mask[k] && (CW'(k) < tail)) begin
          list_r[k] <= list_up[k];
        end
      end
    end
  end

  // Occupancy, fault count and frame-count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fault_r <= '0;
      nf_r    <= lru_pkg::NUM_FRAMES_RST;
    end else begin
      if (cfg_we) begin
        nf_r <= cfg_wdata;
      end
      if (cmd.update) begin
        if (eos_r) begin
          count_r <= '0;
          fault_r <= '0;
        end else begin
          count_r <= count_nxt;
          fault_r <= fault_nxt;
        end
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r      <= hit;
      out_ev_valid_r <= !hit && full;
      out_ev_page_r  <= (!hit && full) ? lru_pkg::PAGE_W'(list_r[0]) : '0;
      out_fault_r    <= fault_nxt;
      out_occ_r      <= lru_pkg::OCC_W'(count_nxt);
    end
  end

  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_ev_valid  = out_ev_valid_r;
  assign out_ev_page   = out_ev_page_r;
  assign out_fault     = out_fault_r;
  assign out_occ       = out_occ_r;

endmodule

>>> sv/lru_page_replacement.sv
// Top level of the LRU page replacement tracker.
//
//  Channel  Direction  Ports                        Word
//  in_      slave      tvalid tready tdata tlast    page request, tlast ends the sequence
//  out_     master     tvalid tready tdata tuser    hit, eviction, fault count, occupancy
//  cfg_     write      we wdata                     number of frames in use
//
// Each request runs through capture, a registered compare against all
// slots, then the list update that also loads the result register.
// The next request is taken once the update has run; a waiting result word
// holds the update step, and with it the input, until the receiver takes it.
// Reset clears the list occupancy, the fault count and the result valid, and
// sets the frame count to four. The list storage itself is not cleared.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] page
  input  logic        in_tlast,   // end_of_sequence
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] evicted_page, [31:16] fault_count, [36:32] occupancy
  output logic [1:0]  out_tuser,  // [0] hit, [1] evicted_valid
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata   // num_frames
);

  lru_pkg::ctrl_cmd_t cmd;
  lru_pkg::dp_stat_t  stat;

  logic                        hit;
  logic                        ev_valid;
  logic [lru_pkg::PAGE_W-1:0]  ev_page;
  logic [lru_pkg::FAULT_W-1:0] fault;
  logic [lru_pkg::OCC_W-1:0]   occ;

  lru_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lru_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_page      (in_tdata),
    .in_eos       (in_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_hit      (hit),
    .out_ev_valid (ev_valid),
    .out_ev_page  (ev_page),
    .out_fault    (fault),
    .out_occ      (occ)
  );

  // Pack the result word.
  assign out_tdata = {3'b000, occ, fault, ev_page};
  assign out_tuser = {ev_valid, hit};

endmodule

>>> sv/lru_checker.sv
// Port-level checker for the LRU page tracker and its bind to the top level.
module lru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted page reads as zero.
  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[15:0] == 16'd0)
    else $error("evicted page nonzero without eviction");

  // A miss always leaves a nonzero fault count.
  a_miss_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:16] != 16'd0)
    else $error("miss reported with zero fault count");

  // An eviction happens only with a nonempty list.
  a_ev_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[36:32] != 5'd0)
    else $error("eviction reported with empty list");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
